// ----- hw/rtl/sme_pkg.sv -----
// Package for the stack machine execute unit.
// Types, opcodes and sizing constants shared by the front, back and output queue.
// No dependencies.
package sme_pkg;

  localparam int STACK_DEPTH   = 256;
  localparam int GLOBALS_DEPTH = 256;
  localparam int PC_WIDTH      = 16;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = SAW + 1;
  localparam int GAW = $clog2(GLOBALS_DEPTH);

  typedef enum logic [4:0] {
    OP_HALT   = 5'd0,
    OP_CONST  = 5'd1,
    OP_ADD    = 5'd2,
    OP_SUB    = 5'd3,
    OP_MUL    = 5'd4,
    OP_LT     = 5'd5,
    OP_EQ     = 5'd6,
    OP_JMP    = 5'd7,
    OP_JMPT   = 5'd8,
    OP_JMPF   = 5'd9,
    OP_LOAD   = 5'd10,
    OP_STORE  = 5'd11,
    OP_GLOAD  = 5'd12,
    OP_GSTORE = 5'd13,
    OP_CALL   = 5'd14,
    OP_RET    = 5'd15,
    OP_POP    = 5'd16,
    OP_PRINT  = 5'd17,
    OP_NOP    = 5'd18
  } op_t;

  typedef enum logic {
    ST_EXEC,
    ST_WAIT
  } be_state_t;

  typedef struct packed {
    logic [4:0]         req_type;
    logic signed [31:0] operand;
    logic [7:0]         arg_count;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               halted;
    logic               fault;
  } out_beat_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] operand;
    logic [7:0]  argc;
    logic [1:0]  len;
  } instr_t;

endpackage

// ----- hw/rtl/sme_front.sv -----
// Front end: accepts instruction beats, decodes opcode and length,
// and holds them in a two-entry queue for the back end. Uses sme_pkg.
module sme_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sme_pkg::in_beat_t in_data,
  output logic              q_valid,
  output sme_pkg::instr_t   q_item,
  input  logic              q_pop
);
  import sme_pkg::*;

  instr_t     q_mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  instr_t     dec;
  logic       push;

  always_comb begin
    dec.operand = in_data.operand;
    dec.argc    = in_data.arg_count;
    if (in_data.req_type <= 5'd17) begin
      dec.op = op_t'(in_data.req_type);
    end else begin
      dec.op = OP_NOP;
    end
    unique case (dec.op)
      OP_CONST, OP_JMP, OP_JMPT, OP_JMPF, OP_LOAD, OP_STORE, OP_GSTORE: dec.len = 2'd2;
      OP_CALL: dec.len = 2'd3;
      default: dec.len = 2'd1;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/sme_outq.sv -----
// Output queue: two-entry buffer between the back end and the result channel.
// Uses sme_pkg.
module sme_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  sme_pkg::out_beat_t res,
  output logic               res_space,
  output logic               out_valid,
  input  logic               out_stall,
  output sme_pkg::out_beat_t out_data
);
  import sme_pkg::*;

  out_beat_t  mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign res_space = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wp_nxt  = res_valid ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(res_valid) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      mem_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/sme_back.sv -----
// Back end: sequences each decoded instruction over the operand stack memory
// and the globals memory, at most one stack access a cycle. Uses sme_pkg.
module sme_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_pc,
  input  logic               q_valid,
  input  sme_pkg::instr_t    q_item,
  output logic               q_pop,
  input  logic               out_space,
  output logic               res_valid,
  output sme_pkg::out_beat_t res
);
  import sme_pkg::*;

  be_state_t             st_r, st_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [SCW-1:0]        cnt_r, cnt_nxt;
  logic [SAW-1:0]        fp_r, fp_nxt;
  logic [PC_WIDTH-1:0]   pc_r, pc_nxt;
  logic                  halt_r, halt_nxt;
  logic                  fault_r, fault_nxt;
  logic                  und_r, und_nxt;
  logic                  gsel_r, gsel_nxt;
  logic [31:0]           res_r, res_nxt;
  logic [31:0]           p_r [4];

  logic [31:0]           stk_mem [STACK_DEPTH];
  logic [31:0]           stk_q;
  logic [31:0]           g_mem [GLOBALS_DEPTH];
  logic [31:0]           g_q;
  logic                  g_vq;
  logic [GLOBALS_DEPTH-1:0] g_vld_r;

  logic                  rd_en, wr_en, grd_en, gwr_en;
  logic [SAW-1:0]        rd_addr, wr_addr;
  logic [31:0]           wr_data, gwr_data;
  logic [GAW-1:0]        grd_addr, gwr_addr;

  logic                  pop_req, push_req, done, f_now, pv, fault_cur;
  logic [31:0]           push_val, pval, wait_val;
  logic [PC_WIDTH-1:0]   nxt, target;
  logic signed [33:0]    idx;
  logic                  idx_ok;

  assign target = q_item.operand[PC_WIDTH-1:0];
  assign idx    = $signed({{(34-SAW){1'b0}}, fp_r})
                + $signed({{2{q_item.operand[31]}}, q_item.operand});
  assign idx_ok = !idx[33] && (idx < 34'(STACK_DEPTH));

  always_comb begin
    if (und_r) begin
      wait_val = '0;
    end else if (gsel_r) begin
      wait_val = g_vq ? g_q : '0;
    end else begin
      wait_val = stk_q;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    fp_nxt   = fp_r;
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    und_nxt  = und_r;
    gsel_nxt = gsel_r;
    res_nxt  = res_r;
    pop_req  = 1'b0;
    push_req = 1'b0;
    push_val = '0;
    done     = 1'b0;
    f_now    = 1'b0;
    pv       = 1'b0;
    pval     = '0;
    nxt      = pc_r + PC_WIDTH'(q_item.len);
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    grd_en   = 1'b0;
    grd_addr = '0;
    gwr_en   = 1'b0;
    gwr_addr = '0;
    gwr_data = '0;
    q_pop    = 1'b0;
    res_valid = 1'b0;

    unique case (st_r)
      ST_EXEC: begin
        if (q_valid && out_space) begin
          if (halt_r) begin
            done = 1'b1;
            nxt  = pc_r;
          end else begin
            unique case (q_item.op)
              OP_HALT: begin
                halt_nxt = 1'b1;
                done     = 1'b1;
              end
              OP_CONST: begin
                push_req = 1'b1;
                push_val = q_item.operand;
                done     = 1'b1;
              end
              OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_EQ: begin
                unique case (step_r)
                  3'd0, 3'd1: pop_req = 1'b1;
                  3'd2: begin
                    unique case (q_item.op)
                      OP_ADD: res_nxt = p_r[0] + p_r[1];
                      OP_SUB: res_nxt = p_r[0] - p_r[1];
                      OP_MUL: res_nxt = p_r[0] * p_r[1];
                      OP_LT:  res_nxt = {31'd0, $signed(p_r[0]) < $signed(p_r[1])};
                      default: res_nxt = {31'd0, p_r[0] == p_r[1]};
                    endcase
                    step_nxt = step_r + 3'd1;
                  end
                  default: begin
                    push_req = 1'b1;
                    push_val = res_r;
                    done     = 1'b1;
                  end
                endcase
              end
              OP_JMP: begin
                nxt  = target;
                done = 1'b1;
              end
              OP_JMPT, OP_JMPF, OP_POP, OP_PRINT: begin
                if (step_r == 3'd0) begin
                  pop_req = 1'b1;
                end else begin
                  done = 1'b1;
                  if ((q_item.op == OP_JMPT) && (p_r[0] != 32'd0)) begin
                    nxt = target;
                  end
                  if ((q_item.op == OP_JMPF) && (p_r[0] == 32'd0)) begin
                    nxt = target;
                  end
                  if (q_item.op == OP_PRINT) begin
                    pv   = !und_r;
                    pval = p_r[0];
                  end
                end
              end
              OP_LOAD: begin
                if (step_r == 3'd0) begin
                  rd_en    = idx_ok;
                  rd_addr  = idx[SAW-1:0];
                  und_nxt  = !idx_ok;
                  gsel_nxt = 1'b0;
                  st_nxt   = ST_WAIT;
                end else begin
                  push_req = 1'b1;
                  push_val = p_r[0];
                  done     = 1'b1;
                end
              end
              OP_STORE: begin
                if (step_r == 3'd0) begin
                  pop_req = 1'b1;
                end else begin
                  wr_en   = idx_ok;
                  wr_addr = idx[SAW-1:0];
                  wr_data = p_r[0];
                  done    = 1'b1;
                end
              end
              OP_GLOAD: begin
                unique case (step_r)
                  3'd0: pop_req = 1'b1;
                  3'd1: begin
                    grd_en   = (p_r[0] < 32'(GLOBALS_DEPTH));
                    grd_addr = p_r[0][GAW-1:0];
                    und_nxt  = !(p_r[0] < 32'(GLOBALS_DEPTH));
                    gsel_nxt = 1'b1;
                    st_nxt   = ST_WAIT;
                  end
                  default: begin
                    push_req = 1'b1;
                    push_val = p_r[0];
                    done     = 1'b1;
                  end
                endcase
              end
              OP_GSTORE: begin
                if (step_r == 3'd0) begin
                  pop_req = 1'b1;
                end else begin
                  gwr_en   = (q_item.operand < 32'(GLOBALS_DEPTH));
                  gwr_addr = q_item.operand[GAW-1:0];
                  gwr_data = p_r[0];
                  done     = 1'b1;
                end
              end
              OP_CALL: begin
                unique case (step_r)
                  3'd0: begin
                    push_req = 1'b1;
                    push_val = {24'd0, q_item.argc};
                  end
                  3'd1: begin
                    push_req = 1'b1;
                    push_val = 32'(fp_r);
                  end
                  3'd2: begin
                    push_req = 1'b1;
                    push_val = 32'(PC_WIDTH'(pc_r + PC_WIDTH'(3)));
                  end
                  default: begin
                    fp_nxt = (cnt_r == '0) ? '0 : SAW'(cnt_r - SCW'(1));
                    nxt    = target;
                    done   = 1'b1;
                  end
                endcase
                if (step_r < 3'd3) begin
                  step_nxt = step_r + 3'd1;
                end
              end
              OP_RET: begin
                unique case (step_r)
                  3'd0, 3'd2, 3'd3, 3'd4: pop_req = 1'b1;
                  3'd1: begin
                    cnt_nxt  = {1'b0, fp_r} + SCW'(1);
                    step_nxt = step_r + 3'd1;
                  end
                  3'd5: begin
                    if (p_r[1][31]) begin
                      fp_nxt = '0;
                    end else if (p_r[1] > 32'(STACK_DEPTH - 1)) begin
                      fp_nxt = SAW'(STACK_DEPTH - 1);
                    end else begin
                      fp_nxt = p_r[1][SAW-1:0];
                    end
                    if (p_r[0] > 32'(cnt_r)) begin
                      f_now   = 1'b1;
                      cnt_nxt = '0;
                    end else begin
                      cnt_nxt = cnt_r - p_r[0][SCW-1:0];
                    end
                    step_nxt = step_r + 3'd1;
                  end
                  default: begin
                    push_req = 1'b1;
                    push_val = p_r[3];
                    nxt      = p_r[2][PC_WIDTH-1:0];
                    done     = 1'b1;
                  end
                endcase
              end
              default: done = 1'b1;
            endcase
          end
        end
      end
      ST_WAIT: begin
        st_nxt   = ST_EXEC;
        step_nxt = step_r + 3'd1;
      end
      default: st_nxt = ST_EXEC;
    endcase

    if (pop_req) begin
      st_nxt   = ST_WAIT;
      gsel_nxt = 1'b0;
      if (cnt_r == '0) begin
        und_nxt = 1'b1;
        f_now   = 1'b1;
      end else begin
        und_nxt = 1'b0;
        rd_en   = 1'b1;
        rd_addr = SAW'(cnt_r - SCW'(1));
        cnt_nxt = cnt_r - SCW'(1);
      end
    end

    if (push_req) begin
      if (cnt_r == SCW'(STACK_DEPTH)) begin
        f_now = 1'b1;
      end else begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[SAW-1:0];
        wr_data = push_val;
        cnt_nxt = cnt_r + SCW'(1);
      end
    end

    fault_cur = fault_r | f_now;
    fault_nxt = fault_cur;
    if (done) begin
      q_pop     = 1'b1;
      res_valid = 1'b1;
      step_nxt  = 3'd0;
      pc_nxt    = nxt;
      fault_nxt = 1'b0;
    end
    if (cfg_we) begin
      pc_nxt = PC_WIDTH'(cfg_pc);
    end

    res.next_pc     = 16'(nxt);
    res.print_valid = pv;
    res.print_value = pval;
    res.halted      = halt_nxt;
    res.fault       = fault_cur;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stk_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      stk_q <= stk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (gwr_en) begin
      g_mem[gwr_addr] <= gwr_data;
    end
    if (grd_en) begin
      g_q  <= g_mem[grd_addr];
      g_vq <= g_vld_r[grd_addr];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (st_r == ST_WAIT) begin
      p_r[0] <= wait_val;
      p_r[1] <= p_r[0];
      p_r[2] <= p_r[1];
      p_r[3] <= p_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_EXEC;
      step_r  <= 3'd0;
      cnt_r   <= '0;
      fp_r    <= '0;
      pc_r    <= '0;
      halt_r  <= 1'b0;
      fault_r <= 1'b0;
      und_r   <= 1'b0;
      gsel_r  <= 1'b0;
      g_vld_r <= '0;
    end else begin
      st_r    <= st_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      fp_r    <= fp_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      fault_r <= fault_nxt;
      und_r   <= und_nxt;
      gsel_r  <= gsel_nxt;
      if (gwr_en) begin
        g_vld_r[gwr_addr] <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/stack_machine_execute_unit.sv -----
// Top level of the stack machine execute unit.
// Instantiates sme_front, sme_back and sme_outq; uses sme_pkg.
//
// Usage:
//   in_valid/in_stall/in_data carry one fetched instruction per beat
//   (opcode, operand, argument count). out_valid/out_stall/out_data carry
//   exactly one result beat per instruction: next fetch address, print
//   value, halted and fault flags, in instruction order.
//   cfg_valid/cfg_ready/cfg_data write the entry address; cfg_ready is
//   always high and the write also loads the program counter.
// Sequencing:
//   A stack pop passes through a wait state for the registered read port; a
//   push does not. Jump, halt, const and no-op need no wait state. The result
//   beat enters the output queue in the instruction's last step.
//   Two-entry queues sit on the input and output sides, so beats are taken
//   while earlier work runs; jump, halt, const and no-op run one beat a cycle
//   while the input queue holds beats and the output queue has space.
// Reset: stack empty, frame pointer and PC zero, globals read 0 until written.
// A stalled receiver fills the output queue; the back end then holds and the
// input queue fills and raises in_stall.
module stack_machine_execute_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sme_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sme_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import sme_pkg::*;

  logic      q_valid, q_pop, res_valid, res_space, cfg_we;
  instr_t    q_item;
  out_beat_t res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  sme_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sme_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_pc    (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_space (res_space),
    .res_valid (res_valid),
    .res       (res)
  );

  sme_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_space (res_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
